>>> sv/btrl_pkg.sv
// Shared types, sizes and codes for the binary trie route lookup block.
`default_nettype none
package btrl_pkg;

  // Table sizing
  localparam int NODES_PER_LEVEL = 1024;
  localparam int HOP_ENTRIES     = 64;
  localparam int ADDR_BITS       = 32;

  localparam int IDX_W      = $clog2(NODES_PER_LEVEL);
  localparam int HOP_W      = $clog2(HOP_ENTRIES);
  localparam int LV_W       = $clog2(ADDR_BITS + 1);
  localparam int FL_W       = $clog2(ADDR_BITS);
  localparam int NODE_W     = 2 * IDX_W + HOP_W;
  localparam int NODE_DEPTH = (ADDR_BITS + 1) << IDX_W;
  localparam int NA_W       = LV_W + IDX_W;
  localparam int HOP_DW     = 36;

  // Request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [5:0]  prefix_length;
    logic [31:0] gateway_addr;
    logic [3:0]  out_port;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  hop_index;
    logic [31:0] hop_addr;
    logic [3:0]  hop_port;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [HOP_W-1:0] hop;
  } node_t;

  typedef struct packed {
    logic [31:0] gw;
    logic [3:0]  port;
  } hop_ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_WALK,
    S_INS_CLR,
    S_LK_WALK,
    S_LK_HOP,
    S_RM_WALK,
    S_RM_CHK,
    S_RM_PAR,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

>>> sv/binary_trie_route_lookup_core.sv
// Top level: binary trie IPv4 route table with insert, remove and lookup.
//
// Usage:
//  - in_valid/in_ready/in_data carry one request beat: kind, address,
//    prefix_length, gateway_addr, out_port. Each request gives one result.
//  - out_valid/out_ready/out_data carry one result beat: status, hop_index,
//    hop_addr, hop_port.
//  - One request is worked at a time. A lookup does one node memory read
//    per trie level walked, then one next-hop table read if a next hop was
//    found. Insert first scans the used next-hop entries (a read state and a
//    compare state per entry) and then walks the prefix, linking and then
//    clearing each newly allocated node. Remove walks the prefix, then
//    prunes empty nodes upward, checking and unlinking one level at a time.
//  - The root node lives in flip-flops; all other nodes live in one node
//    memory, and next hops in a second memory, both with registered reads.
//  - Synchronous reset (rst_n low) empties the root, the fill counters and
//    the next-hop count; no clearing pass is needed.
//  - A finished result sits in the output register while the next request
//    is accepted; if out_ready stays low, a second result waits in the
//    core until the output register frees.
`default_nettype none
module binary_trie_route_lookup_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire btrl_pkg::in_t    in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output btrl_pkg::out_t        out_data
);

  localparam int IDX_W = btrl_pkg::IDX_W;
  localparam int HOP_W = btrl_pkg::HOP_W;
  localparam int LV_W  = btrl_pkg::LV_W;
  localparam int FL_W  = btrl_pkg::FL_W;
  localparam int AB    = btrl_pkg::ADDR_BITS;

  // Control and payload registers
  btrl_pkg::state_t state_r, state_nxt;
  btrl_pkg::in_t    req_r, req_nxt;
  logic [LV_W-1:0]  len_r, len_nxt;
  logic [LV_W-1:0]  lv_r, lv_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  btrl_pkg::node_t  node_r, node_nxt;
  logic             use_ram_r, use_ram_nxt;
  logic [HOP_W-1:0] idx_r, idx_nxt;
  logic [HOP_W-1:0] k_r, k_nxt;
  btrl_pkg::out_t   res_r, res_nxt;
  btrl_pkg::out_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  btrl_pkg::node_t  root_r;
  logic [HOP_W-1:0] hop_count_r, hop_count_nxt;
  logic [IDX_W-1:0] fill_r [AB];
  logic [IDX_W-1:0] path_r [AB];

  // Write strobes from the sequencer
  logic             node_we;
  logic [LV_W-1:0]  node_wlv;
  logic [IDX_W-1:0] node_widx;
  btrl_pkg::node_t  node_wdata;
  logic [btrl_pkg::NA_W-1:0]  node_raddr;
  logic [btrl_pkg::NODE_W-1:0] node_rdata;
  logic             fill_we;
  logic [IDX_W-1:0] fill_wdata;
  logic             path_we;
  logic             hop_we;
  logic [HOP_W-1:0] hop_waddr, hop_raddr;
  btrl_pkg::hop_ent_t hop_wdata;
  logic [btrl_pkg::HOP_DW-1:0] hop_rdata;

  // Walk helpers
  btrl_pkg::node_t  node;
  logic [AB-1:0]    abits;
  logic             bit_dn, bit_up;
  logic [IDX_W-1:0] link;
  logic [LV_W-1:0]  lvm1, lvm2;
  logic [IDX_W-1:0] pidx;
  logic [HOP_W-1:0] hidx;
  btrl_pkg::node_t  nmod;
  btrl_pkg::hop_ent_t hent;

  assign in_ready  = (state_r == btrl_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign node  = use_ram_r ? btrl_pkg::node_t'(node_rdata) : node_r;
  assign abits = req_r.address[AB-1:0];
  assign lvm1  = lv_r - LV_W'(1);
  assign lvm2  = lv_r - LV_W'(2);
  assign bit_dn = abits[lv_r[FL_W-1:0]];
  assign bit_up = abits[lvm1[FL_W-1:0]];
  assign link  = bit_dn ? node.right : node.left;
  assign pidx  = (lv_r == LV_W'(1)) ? '0 : path_r[lvm2[FL_W-1:0]];
  assign hent  = btrl_pkg::hop_ent_t'(hop_rdata);

  // Node memory: levels 1..ADDR_BITS, addressed {level, index}
  btrl_ram #(
    .WIDTH(btrl_pkg::NODE_W),
    .DEPTH(btrl_pkg::NODE_DEPTH)
  ) u_node_ram (
    .clk  (clk),
    .we   (node_we && (node_wlv != '0)),
    .waddr({node_wlv, node_widx}),
    .wdata(node_wdata),
    .raddr(node_raddr),
    .rdata(node_rdata)
  );

  // Next-hop table; entry zero is never read
  btrl_ram #(
    .WIDTH(btrl_pkg::HOP_DW),
    .DEPTH(btrl_pkg::HOP_ENTRIES)
  ) u_hop_ram (
    .clk  (clk),
    .we   (hop_we),
    .waddr(hop_waddr),
    .wdata(hop_wdata),
    .raddr(hop_raddr),
    .rdata(hop_rdata)
  );

  // Sequencer: next state and memory accesses
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    len_nxt       = len_r;
    lv_nxt        = lv_r;
    cur_nxt       = cur_r;
    node_nxt      = node;
    use_ram_nxt   = 1'b0;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    hop_count_nxt = hop_count_r;
    node_we       = 1'b0;
    node_wlv      = lv_r;
    node_widx     = cur_r;
    node_wdata    = node;
    node_raddr    = '0;
    fill_we       = 1'b0;
    fill_wdata    = fill_r[lv_r[FL_W-1:0]] + IDX_W'(1);
    path_we       = 1'b0;
    hop_we        = 1'b0;
    hop_waddr     = idx_r;
    hop_wdata     = '{gw: req_r.gateway_addr, port: req_r.out_port};
    hop_raddr     = k_r;
    hidx          = idx_r;
    nmod          = node;

    case (state_r)
      btrl_pkg::S_IDLE: begin
        node_nxt = root_r;
        if (in_valid) begin
          req_nxt = in_data;
          len_nxt = (in_data.prefix_length > 6'(AB)) ? LV_W'(AB)
                                                     : LV_W'(in_data.prefix_length);
          lv_nxt  = '0;
          cur_nxt = '0;
          k_nxt   = HOP_W'(1);
          case (in_data.kind)
            btrl_pkg::KIND_INSERT: begin
              idx_nxt   = '0;
              state_nxt = (hop_count_r == '0) ? btrl_pkg::S_INS_WALK
                                              : btrl_pkg::S_SCAN_RD;
            end
            btrl_pkg::KIND_REMOVE: state_nxt = btrl_pkg::S_RM_WALK;
            btrl_pkg::KIND_LOOKUP: begin
              idx_nxt   = root_r.hop;
              state_nxt = btrl_pkg::S_LK_WALK;
            end
            default: begin
              res_nxt   = '{status: btrl_pkg::STAT_MISS, default: '0};
              state_nxt = btrl_pkg::S_RESP;
            end
          endcase
        end
      end

      // Dedup scan over used next-hop entries
      btrl_pkg::S_SCAN_RD: state_nxt = btrl_pkg::S_SCAN_CMP;

      btrl_pkg::S_SCAN_CMP: begin
        if (hent.gw == req_r.gateway_addr && hent.port == req_r.out_port) begin
          idx_nxt   = k_r;
          state_nxt = btrl_pkg::S_INS_WALK;
        end else if (k_r == hop_count_r) begin
          if (hop_count_r == HOP_W'(btrl_pkg::HOP_ENTRIES - 1)) begin
            res_nxt   = '{status: btrl_pkg::STAT_FULL, default: '0};
            state_nxt = btrl_pkg::S_RESP;
          end else begin
            state_nxt = btrl_pkg::S_INS_WALK;
          end
        end else begin
          k_nxt     = k_r + HOP_W'(1);
          state_nxt = btrl_pkg::S_SCAN_RD;
        end
      end

      // Insert walk, allocating missing nodes
      btrl_pkg::S_INS_WALK: begin
        if (lv_r == len_r) begin
          if (idx_r == '0) begin
            hidx          = hop_count_r + HOP_W'(1);
            hop_count_nxt = hidx;
            hop_we        = 1'b1;
            hop_waddr     = hidx;
          end
          nmod.hop   = hidx;
          node_we    = 1'b1;
          node_wdata = nmod;
          res_nxt    = '{status: btrl_pkg::STAT_OK, hop_index: 6'(hidx),
                         hop_addr: req_r.gateway_addr, hop_port: req_r.out_port};
          state_nxt  = btrl_pkg::S_RESP;
        end else if (link != '0) begin
          node_raddr  = {lv_r + LV_W'(1), link};
          cur_nxt     = link;
          lv_nxt      = lv_r + LV_W'(1);
          use_ram_nxt = 1'b1;
        end else if (fill_r[lv_r[FL_W-1:0]] == IDX_W'(btrl_pkg::NODES_PER_LEVEL - 1)) begin
          res_nxt   = '{status: btrl_pkg::STAT_FULL, default: '0};
          state_nxt = btrl_pkg::S_RESP;
        end else begin
          fill_we = 1'b1;
          if (bit_dn) nmod.right = fill_wdata;
          else        nmod.left  = fill_wdata;
          node_we    = 1'b1;
          node_wdata = nmod;
          cur_nxt    = fill_wdata;
          lv_nxt     = lv_r + LV_W'(1);
          node_nxt   = '0;
          state_nxt  = btrl_pkg::S_INS_CLR;
        end
      end

      // Clear the freshly allocated node
      btrl_pkg::S_INS_CLR: begin
        node_we    = 1'b1;
        node_wdata = '0;
        node_nxt   = '0;
        state_nxt  = btrl_pkg::S_INS_WALK;
      end

      // Lookup walk, keeping the deepest next hop
      btrl_pkg::S_LK_WALK: begin
        if (use_ram_r && node.hop != '0) hidx = node.hop;
        idx_nxt = hidx;
        if (lv_r == LV_W'(AB) || link == '0) begin
          if (hidx == '0) begin
            res_nxt   = '{status: btrl_pkg::STAT_MISS, default: '0};
            state_nxt = btrl_pkg::S_RESP;
          end else begin
            hop_raddr = hidx;
            state_nxt = btrl_pkg::S_LK_HOP;
          end
        end else begin
          node_raddr  = {lv_r + LV_W'(1), link};
          cur_nxt     = link;
          lv_nxt      = lv_r + LV_W'(1);
          use_ram_nxt = 1'b1;
        end
      end

      btrl_pkg::S_LK_HOP: begin
        res_nxt   = '{status: btrl_pkg::STAT_OK, hop_index: 6'(idx_r),
                      hop_addr: hent.gw, hop_port: hent.port};
        state_nxt = btrl_pkg::S_RESP;
      end

      // Remove walk, recording the path
      btrl_pkg::S_RM_WALK: begin
        if (lv_r == len_r) begin
          nmod.hop   = '0;
          node_we    = 1'b1;
          node_wdata = nmod;
          node_nxt   = nmod;
          state_nxt  = btrl_pkg::S_RM_CHK;
        end else if (link == '0) begin
          res_nxt   = '{status: btrl_pkg::STAT_MISS, default: '0};
          state_nxt = btrl_pkg::S_RESP;
        end else begin
          path_we     = 1'b1;
          node_raddr  = {lv_r + LV_W'(1), link};
          cur_nxt     = link;
          lv_nxt      = lv_r + LV_W'(1);
          use_ram_nxt = 1'b1;
        end
      end

      // Prune: stop at the root or at a node still in use
      btrl_pkg::S_RM_CHK: begin
        if (lv_r == '0 || node.left != '0 || node.right != '0 || node.hop != '0) begin
          res_nxt   = '{status: btrl_pkg::STAT_OK, default: '0};
          state_nxt = btrl_pkg::S_RESP;
        end else begin
          node_raddr  = {lvm1, pidx};
          node_nxt    = root_r;
          use_ram_nxt = (lv_r != LV_W'(1));
          state_nxt   = btrl_pkg::S_RM_PAR;
        end
      end

      btrl_pkg::S_RM_PAR: begin
        if (bit_up) nmod.right = '0;
        else        nmod.left  = '0;
        node_we    = 1'b1;
        node_wlv   = lvm1;
        node_widx  = pidx;
        node_wdata = nmod;
        node_nxt   = nmod;
        cur_nxt    = pidx;
        lv_nxt     = lvm1;
        state_nxt  = btrl_pkg::S_RM_CHK;
      end

      // Hand the result to the output register
      btrl_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = btrl_pkg::S_IDLE;
        end
      end

      default: state_nxt = btrl_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btrl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      hop_count_r <= '0;
      root_r      <= '0;
      use_ram_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hop_count_r <= hop_count_nxt;
      use_ram_r   <= use_ram_nxt;
      if (node_we && node_wlv == '0) begin
        root_r <= node_wdata;
      end
    end
  end

  // Per-level fill counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AB; i++) fill_r[i] <= '0;
    end else if (fill_we) begin
      fill_r[lv_r[FL_W-1:0]] <= fill_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    len_r  <= len_nxt;
    lv_r   <= lv_nxt;
    cur_r  <= cur_nxt;
    node_r <= node_nxt;
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    if (path_we) begin
      path_r[lv_r[FL_W-1:0]] <= link;
    end
  end

  // Checks
  a_hop_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hop_count_r <= HOP_W'(btrl_pkg::HOP_ENTRIES - 1))
    else $error("next-hop count beyond table");

  a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btrl_pkg::S_INS_WALK || state_r == btrl_pkg::S_RM_WALK)
      |-> lv_r <= len_r)
    else $error("walk went past the prefix length");

  a_lookup_depth: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == btrl_pkg::S_LK_WALK |-> lv_r <= LV_W'(AB))
    else $error("lookup walked past the last level");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule
`default_nettype wire

>>> sv/btrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the binary trie route lookup core.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  btrl_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  btrl_pkg::out_t out_data;

  binary_trie_route_lookup_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow trie: left, right and hop per node, per level
  int unsigned trie_left [btrl_pkg::ADDR_BITS+1][btrl_pkg::NODES_PER_LEVEL];
  int unsigned trie_right[btrl_pkg::ADDR_BITS+1][btrl_pkg::NODES_PER_LEVEL];
  int unsigned trie_hop  [btrl_pkg::ADDR_BITS+1][btrl_pkg::NODES_PER_LEVEL];
  int unsigned fill_cnt[btrl_pkg::ADDR_BITS];
  logic [31:0] gw_tab[btrl_pkg::HOP_ENTRIES];
  logic [3:0] port_tab[btrl_pkg::HOP_ENTRIES];
  int unsigned hops_used;

  btrl_pkg::out_t expected_routes[$];
  int mismatches;
  int cycle_cnt;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_recv;
  logic [31:0] known_prefix[$];
  logic [5:0] known_len[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned child(int lv, int unsigned n, bit b);
    return b ? trie_right[lv][n] : trie_left[lv][n];
  endfunction

  function automatic void set_child(int lv, int unsigned n, bit b, int unsigned v);
    if (b) trie_right[lv][n] = v;
    else trie_left[lv][n] = v;
  endfunction

  function automatic void clear_trie();
    trie_left[0][0] = 0;
    trie_right[0][0] = 0;
    trie_hop[0][0] = 0;
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
    foreach (gw_tab[i]) begin
      gw_tab[i] = '0;
      port_tab[i] = '0;
    end
    hops_used = 0;
  endfunction

  // Predict the result of one request and update the shadow state
  function automatic btrl_pkg::out_t route_predict(btrl_pkg::in_t req);
    btrl_pkg::out_t r;
    int unsigned len, idx, cur, nxt;
    int unsigned path[btrl_pkg::ADDR_BITS+1];
    bit b;
    r = '0;
    r.status = btrl_pkg::STAT_MISS;
    len = (req.prefix_length > btrl_pkg::ADDR_BITS) ? btrl_pkg::ADDR_BITS
                                                    : req.prefix_length;
    cur = 0;
    case (req.kind)
      btrl_pkg::KIND_INSERT: begin
        idx = 0;
        for (int k = 1; k <= hops_used && k < btrl_pkg::HOP_ENTRIES; k++) begin
          if (gw_tab[k] == req.gateway_addr && port_tab[k] == req.out_port) begin
            idx = k;
            break;
          end
        end
        if (idx == 0 && hops_used >= btrl_pkg::HOP_ENTRIES - 1) begin
          r.status = btrl_pkg::STAT_FULL;
          return r;
        end
        for (int lv = 0; lv < len; lv++) begin
          b = req.address[lv];
          nxt = child(lv, cur, b);
          if (nxt == 0) begin
            if (fill_cnt[lv] >= btrl_pkg::NODES_PER_LEVEL - 1) begin
              r.status = btrl_pkg::STAT_FULL;
              return r;
            end
            fill_cnt[lv]++;
            nxt = fill_cnt[lv];
            set_child(lv, cur, b, nxt);
            trie_left[lv+1][nxt] = 0;
            trie_right[lv+1][nxt] = 0;
            trie_hop[lv+1][nxt] = 0;
          end
          cur = nxt;
        end
        if (idx == 0) begin
          hops_used++;
          idx = hops_used;
          gw_tab[idx] = req.gateway_addr;
          port_tab[idx] = req.out_port;
        end
        trie_hop[len][cur] = idx;
        r.status = btrl_pkg::STAT_OK;
        r.hop_index = 6'(idx);
        r.hop_addr = req.gateway_addr;
        r.hop_port = req.out_port;
      end
      btrl_pkg::KIND_REMOVE: begin
        path[0] = 0;
        for (int lv = 0; lv < len; lv++) begin
          nxt = child(lv, cur, req.address[lv]);
          if (nxt == 0 || nxt >= btrl_pkg::NODES_PER_LEVEL) return r;
          cur = nxt;
          path[lv+1] = cur;
        end
        trie_hop[len][cur] = 0;
        // prune empty nodes back toward the root
        for (int lv = len; lv > 0; lv--) begin
          if (trie_left[lv][path[lv]] != 0 || trie_right[lv][path[lv]] != 0 ||
              trie_hop[lv][path[lv]] != 0) break;
          set_child(lv - 1, path[lv-1], req.address[lv-1], 0);
        end
        r.status = btrl_pkg::STAT_OK;
      end
      btrl_pkg::KIND_LOOKUP: begin
        idx = trie_hop[0][0];
        for (int lv = 0; lv < btrl_pkg::ADDR_BITS; lv++) begin
          nxt = child(lv, cur, req.address[lv]);
          if (nxt == 0 || nxt >= btrl_pkg::NODES_PER_LEVEL) break;
          cur = nxt;
          if (trie_hop[lv+1][cur] != 0) idx = trie_hop[lv+1][cur];
        end
        if (idx != 0 && idx < btrl_pkg::HOP_ENTRIES) begin
          r.status = btrl_pkg::STAT_OK;
          r.hop_index = 6'(idx);
          r.hop_addr = gw_tab[idx];
          r.hop_port = port_tab[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one beat, keep valid up until accepted; valid drops while idling
  task automatic send_route_req(btrl_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_routes.push_back(route_predict(req));
    if (req.kind == btrl_pkg::KIND_INSERT && req.prefix_length <= btrl_pkg::ADDR_BITS) begin
      known_prefix.push_back(req.address);
      known_len.push_back(req.prefix_length);
    end
  endtask

  task automatic send_fields(logic [1:0] k, logic [31:0] a, logic [5:0] l,
                             logic [31:0] g, logic [3:0] p);
    btrl_pkg::in_t req;
    req.kind = k;
    req.address = a;
    req.prefix_length = l;
    req.gateway_addr = g;
    req.out_port = p;
    send_route_req(req);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_valid && out_ready) begin
        if (expected_routes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          if (out_data !== expected_routes[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", expected_routes[0], out_data);
          end
          void'(expected_routes.pop_front());
        end
      end
    end
  end

  // Receiver ready generation
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_fields(btrl_pkg::KIND_LOOKUP, 32'h0, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_REMOVE, 32'h1, 6'd1, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_INSERT, 32'h0, 6'd0, 32'hFFFF_FFFF, 4'hF);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0A00_0001, 4'h1);
    send_fields(btrl_pkg::KIND_INSERT, 32'hAAAA_5555, 6'd63, 32'h0A00_0002, 4'h0);
    send_fields(btrl_pkg::KIND_INSERT, 32'h0000_0003, 6'd2, 32'h0A00_0001, 4'h1);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'h0000_0007, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'hAAAA_5555, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'h0000_0002, 6'd0, 32'h0, 4'h0);
    send_fields(KIND_UNKNOWN, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 4'hF);
    send_fields(btrl_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 6'd32, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_REMOVE, 32'hAAAA_5555, 6'd40, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_REMOVE, 32'h0, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'h0000_0003, 6'd0, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_REMOVE, 32'h0000_0003, 6'd2, 32'h0, 4'h0);
    send_fields(btrl_pkg::KIND_LOOKUP, 32'h0000_0003, 6'd0, 32'h0, 4'h0);
    wait_drained();
  endtask

  // Random mix: inserts, lookups, removes (often of known prefixes) and unknown kinds
  task automatic test_random(int count);
    btrl_pkg::in_t req;
    int sel, pick;
    for (int i = 0; i < count; i++) begin
      req.address = $urandom();
      req.gateway_addr = {28'h0A0_0000, 4'($urandom_range(15))};
      if ($urandom_range(9) == 0) req.gateway_addr = $urandom();
      req.out_port = 4'($urandom_range(15));
      req.prefix_length = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(12));
      sel = $urandom_range(99);
      if (sel < 35) req.kind = btrl_pkg::KIND_INSERT;
      else if (sel < 75) req.kind = btrl_pkg::KIND_LOOKUP;
      else if (sel < 97) begin
        req.kind = btrl_pkg::KIND_REMOVE;
        if (known_prefix.size() != 0 && $urandom_range(3) != 0) begin
          pick = $urandom_range(known_prefix.size() - 1);
          req.address = known_prefix[pick];
          req.prefix_length = known_len[pick];
        end
      end else req.kind = KIND_UNKNOWN;
      if (req.kind == btrl_pkg::KIND_LOOKUP && known_prefix.size() != 0 &&
          $urandom_range(1) == 0) begin
        pick = $urandom_range(known_prefix.size() - 1);
        req.address = known_prefix[pick] ^ ($urandom() << known_len[pick]);
      end
      send_route_req(req);
    end
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      test_random(10);
    join
  endtask

  // Fill the next-hop table with fresh gateways past its capacity, then reuse a known gateway
  task automatic test_hop_full();
    for (int i = 0; i < btrl_pkg::HOP_ENTRIES + 3; i++)
      send_fields(btrl_pkg::KIND_INSERT, $urandom(), 6'($urandom_range(3)),
                  32'hC000_0000 + i, 4'($urandom_range(15)));
    send_fields(btrl_pkg::KIND_INSERT, 32'h5, 6'd3, 32'h0A00_0001, 4'h1);
    wait_drained();
  endtask

  // Full-length prefixes along random paths
  task automatic test_node_full();
    for (int i = 0; i < 8; i++)
      send_fields(btrl_pkg::KIND_INSERT, $urandom(), 6'd32, 32'h0A00_0001, 4'h1);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_recv = 1'b0;
    mismatches = 0;
    cycle_cnt = 0;
    send_idle_pct = 22;
    recv_idle_pct = 80;
    clear_trie();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(240);
    send_idle_pct = 80;
    recv_idle_pct = 22;
    test_random(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);
    test_node_full();
    test_hop_full();
    test_random(40);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_routes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
